// ===== rtl/core/bmp24_to_rgb565_pixel_stream_top_defines.svh =====
// ----------------------------------------------------------------------------
// BMP to RGB565 stream - assertion macros
// Concurrent check wrappers; they compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BMP24_TO_RGB565_PIXEL_STREAM_TOP_DEFINES_SVH
`define BMP24_TO_RGB565_PIXEL_STREAM_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge out of reset
`define B2R_ASSERT(label, ck, rn, cond) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond)) \
        else $error("b2r check failed");

// Antecedent implies consequent in the same cycle
`define B2R_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("b2r check failed");

`else

`define B2R_ASSERT(label, ck, rn, cond)
`define B2R_ASSERT_IMP(label, ck, rn, ante, cons)

`endif

`endif

// ===== rtl/core/b2r_pkg.sv =====
// ----------------------------------------------------------------------------
// BMP to RGB565 stream - shared package
// Field widths, configuration register indexes and BMP header constants.
// ----------------------------------------------------------------------------
package b2r_pkg;

    // Channel field widths
    localparam int BYTE_W      = 8;
    localparam int COORD_W     = 16;
    localparam int COLOR_W     = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int POS_W       = 32;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_X = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Y = 8'd1;

    // Header layout: first byte past the fields we capture
    localparam logic [POS_W-1:0] HEADER_END = 32'd29;

    // Header byte positions (all below 32)
    localparam logic [4:0] HDR_OFFSET_B0 = 5'd10;
    localparam logic [4:0] HDR_OFFSET_B1 = 5'd11;
    localparam logic [4:0] HDR_OFFSET_B2 = 5'd12;
    localparam logic [4:0] HDR_OFFSET_B3 = 5'd13;
    localparam logic [4:0] HDR_WIDTH_B0  = 5'd18;
    localparam logic [4:0] HDR_WIDTH_B1  = 5'd19;
    localparam logic [4:0] HDR_HEIGHT_B0 = 5'd22;
    localparam logic [4:0] HDR_HEIGHT_B1 = 5'd23;
    localparam logic [4:0] HDR_DEPTH     = 5'd28;

    localparam logic [7:0] DEPTH_24 = 8'd24;

    // Position of the next data byte within a BGR triplet
    localparam logic [1:0] BIP_BLUE  = 2'd0;
    localparam logic [1:0] BIP_GREEN = 2'd1;
    localparam logic [1:0] BIP_RED   = 2'd2;

endpackage

// ===== rtl/core/b2r_in_if.sv =====
// ----------------------------------------------------------------------------
// BMP to RGB565 stream - byte input channel
// Valid/ready channel carrying one file byte and the start-of-file mark.
// ----------------------------------------------------------------------------
interface b2r_in_if
    import b2r_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] file_byte;
    logic              first_byte;

    modport source (output valid, output file_byte, output first_byte, input ready);
    modport sink   (input valid, input file_byte, input first_byte, output ready);
endinterface

// ===== rtl/core/b2r_out_if.sv =====
// ----------------------------------------------------------------------------
// BMP to RGB565 stream - pixel output channel
// Valid/ready channel carrying one placed RGB565 pixel.
// ----------------------------------------------------------------------------
interface b2r_out_if
    import b2r_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               image_done;

    modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
                    output image_done, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input pixel_color,
                    input image_done, output ready);
endinterface

// ===== rtl/core/b2r_cfg_if.sv =====
// ----------------------------------------------------------------------------
// BMP to RGB565 stream - configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface b2r_cfg_if
    import b2r_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/bmp24_to_rgb565_pixel_stream_top.sv =====
// ----------------------------------------------------------------------------
// BMP to RGB565 stream - top level
// Parses a 24-bit BMP byte stream and emits placed RGB565 pixels.
// ----------------------------------------------------------------------------
//  Channel    Dir  Payload                                         Handshake
//  byte_in    in   file_byte[7:0], first_byte                      valid/ready
//  pixel_out  out  pixel_x[15:0], pixel_y[15:0], pixel_color[15:0],
//                  image_done                                      valid/ready
//  cfg        in   index[7:0], data[15:0]                          valid/ready
//
//  One byte per cycle while byte_in is ready; a pixel appears in the output
//  register in the cycle after the red byte of its triplet is taken.
//  The output register is the only stall point: byte_in is ready whenever it
//  is empty or being drained in the same cycle.
//  Reset clears the parser (as if byte zero comes next) and both origins.
//  cfg is always ready; writes take effect on the next cycle.
// ----------------------------------------------------------------------------
`include "bmp24_to_rgb565_pixel_stream_top_defines.svh"

module bmp24_to_rgb565_pixel_stream_top
    import b2r_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    b2r_in_if.sink     byte_in,
    b2r_out_if.source  pixel_out,
    b2r_cfg_if.sink    cfg
);

    // Configuration
    logic [COORD_W-1:0] origin_x_reg;
    logic [COORD_W-1:0] origin_y_reg;

    // Parser state
    logic [POS_W-1:0]   pos_reg,     pos_next;
    logic [POS_W-1:0]   pds_reg,     pds_next;
    logic [COORD_W-1:0] width_reg,   width_next;
    logic [COORD_W-1:0] height_reg,  height_next;
    logic [7:0]         bpp_reg,     bpp_next;
    logic [COORD_W-1:0] col_reg,     col_next;
    logic [COORD_W-1:0] row_reg,     row_next;
    logic [1:0]         bip_reg,     bip_next;
    logic [1:0]         pad_reg,     pad_next;
    logic [7:0]         blue_reg,    blue_next;
    logic [7:0]         green_reg,   green_next;
    logic               fmt_err_reg, fmt_err_next;

    // Effective state after an optional restart
    logic [POS_W-1:0]   cur_pos, cur_pds;
    logic [COORD_W-1:0] cur_width, cur_height, cur_col, cur_row;
    logic [7:0]         cur_bpp, cur_blue, cur_green;
    logic [1:0]         cur_bip, cur_pad;
    logic               cur_fmt_err;

    // Result register
    logic               out_valid_reg;
    logic [COORD_W-1:0] out_x_reg,     out_x_next;
    logic [COORD_W-1:0] out_y_reg,     out_y_next;
    logic [COLOR_W-1:0] out_color_reg, out_color_next;
    logic               out_done_reg,  out_done_next;

    logic               in_acc;
    logic               emit;
    logic               in_pixels;
    logic               last_col;
    logic               last_row;
    logic [POS_W-1:0]   new_pds;
    logic [BYTE_W-1:0]  b;

    assign b      = byte_in.file_byte;
    assign in_acc = byte_in.valid && byte_in.ready;

    // Input ready while the result register is empty or draining
    assign byte_in.ready = !out_valid_reg || pixel_out.ready;
    assign cfg.ready     = 1'b1;

    // Start mark clears the parse state before the byte is used
    always_comb
    begin
        cur_pos     = byte_in.first_byte ? '0 : pos_reg;
        cur_pds     = byte_in.first_byte ? '0 : pds_reg;
        cur_width   = byte_in.first_byte ? '0 : width_reg;
        cur_height  = byte_in.first_byte ? '0 : height_reg;
        cur_bpp     = byte_in.first_byte ? '0 : bpp_reg;
        cur_col     = byte_in.first_byte ? '0 : col_reg;
        cur_row     = byte_in.first_byte ? '0 : row_reg;
        cur_bip     = byte_in.first_byte ? BIP_BLUE : bip_reg;
        cur_pad     = byte_in.first_byte ? '0 : pad_reg;
        cur_blue    = byte_in.first_byte ? '0 : blue_reg;
        cur_green   = byte_in.first_byte ? '0 : green_reg;
        cur_fmt_err = byte_in.first_byte ? 1'b0 : fmt_err_reg;
    end

    assign last_col = (cur_col == cur_width - 16'd1);
    assign last_row = (cur_row == cur_height - 16'd1);
    assign new_pds  = {b, cur_pds[23:0]};

    assign in_pixels = !cur_fmt_err && (cur_pos >= HEADER_END) && (cur_pos >= cur_pds)
                       && (cur_bpp == DEPTH_24) && (cur_width != '0)
                       && (cur_row < cur_height);

    // Header capture, padding skip and triplet packing
    always_comb
    begin
        pos_next       = cur_pos;
        pds_next       = cur_pds;
        width_next     = cur_width;
        height_next    = cur_height;
        bpp_next       = cur_bpp;
        col_next       = cur_col;
        row_next       = cur_row;
        bip_next       = cur_bip;
        pad_next       = cur_pad;
        blue_next      = cur_blue;
        green_next     = cur_green;
        fmt_err_next   = cur_fmt_err;
        emit           = 1'b0;
        out_x_next     = origin_x_reg + cur_col;
        out_y_next     = origin_y_reg + (cur_height - 16'd1 - cur_row);
        out_color_next = {b[7:3], cur_green[7:2], cur_blue[7:3]};
        out_done_next  = last_col && last_row;

        // A byte at the saturated position is dropped
        if (!(&cur_pos))
        begin
            pos_next = cur_pos + 32'd1;

            if (cur_pos < HEADER_END)
            begin
                unique case (cur_pos[4:0])
                    HDR_OFFSET_B0: pds_next = {cur_pds[31:8], b};
                    HDR_OFFSET_B1: pds_next = {cur_pds[31:16], b, cur_pds[7:0]};
                    HDR_OFFSET_B2: pds_next = {cur_pds[31:24], b, cur_pds[15:0]};
                    HDR_OFFSET_B3:
                    begin
                        pds_next     = new_pds;
                        fmt_err_next = (new_pds < HEADER_END);
                    end
                    HDR_WIDTH_B0:  width_next  = {cur_width[15:8], b};
                    HDR_WIDTH_B1:  width_next  = {b, cur_width[7:0]};
                    HDR_HEIGHT_B0: height_next = {cur_height[15:8], b};
                    HDR_HEIGHT_B1: height_next = {b, cur_height[7:0]};
                    HDR_DEPTH:     bpp_next    = b;
                    default:       ;
                endcase
            end
            else if (in_pixels)
            begin
                if (cur_pad != 2'd0)
                begin
                    pad_next = cur_pad - 2'd1;
                end
                else
                begin
                    case (cur_bip)
                        BIP_BLUE:
                        begin
                            blue_next = b;
                            bip_next  = BIP_GREEN;
                        end
                        BIP_GREEN:
                        begin
                            green_next = b;
                            bip_next   = BIP_RED;
                        end
                        default:
                        begin
                            emit     = 1'b1;
                            bip_next = BIP_BLUE;
                            if (last_col)
                            begin
                                col_next = '0;
                                row_next = cur_row + 16'd1;
                                pad_next = cur_width[1:0];
                            end
                            else
                            begin
                                col_next = cur_col + 16'd1;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_ORIGIN_X)
            begin
                origin_x_reg <= cfg.data;
            end
            if (cfg.index == CFG_ORIGIN_Y)
            begin
                origin_y_reg <= cfg.data;
            end
        end
    end

    // Parser state update on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            pds_reg     <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            bpp_reg     <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            bip_reg     <= BIP_BLUE;
            pad_reg     <= '0;
            blue_reg    <= '0;
            green_reg   <= '0;
            fmt_err_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            pos_reg     <= pos_next;
            pds_reg     <= pds_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            bpp_reg     <= bpp_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            bip_reg     <= bip_next;
            pad_reg     <= pad_next;
            blue_reg    <= blue_next;
            green_reg   <= green_next;
            fmt_err_reg <= fmt_err_next;
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_acc && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pixel_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_acc && emit)
        begin
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_color_reg <= out_color_next;
            out_done_reg  <= out_done_next;
        end
    end

    assign pixel_out.valid       = out_valid_reg;
    assign pixel_out.pixel_x     = out_x_reg;
    assign pixel_out.pixel_y     = out_y_reg;
    assign pixel_out.pixel_color = out_color_reg;
    assign pixel_out.image_done  = out_done_reg;

    // Checks
    `B2R_ASSERT(a_bip_legal, clk, rst_n, bip_reg != 2'd3)
    `B2R_ASSERT_IMP(a_rise_needs_accept, clk, rst_n, $rose(out_valid_reg), $past(in_acc))
    `B2R_ASSERT_IMP(a_no_pixel_on_error, clk, rst_n,
        in_acc && !byte_in.first_byte && fmt_err_reg, !emit)
    `B2R_ASSERT_IMP(a_done_ends_rows, clk, rst_n,
        out_valid_reg && out_done_reg, row_reg == height_reg && col_reg == '0)

endmodule
